// File: rtl/vacc_pkg.sv
// Package: shared types, constants and the microcode program of the climb controller.
package vacc_pkg;

  localparam int unsigned STEP_W = 3;

  localparam logic signed [33:0] INT_LIMIT = 34'sd9830400;
  localparam logic [13:0] FULL_CMD = 14'd9600;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [3:0] REG_ALT_GAIN   = 4'd0;
  localparam logic [3:0] REG_MAX_CLIMB  = 4'd1;
  localparam logic [3:0] REG_CRUISE     = 4'd2;
  localparam logic [3:0] REG_CLIMB_INC  = 4'd3;
  localparam logic [3:0] REG_PGAIN      = 4'd4;
  localparam logic [3:0] REG_IGAIN      = 4'd5;
  localparam logic [3:0] REG_PITCH_GAIN = 4'd6;
  localparam logic [3:0] REG_SLEW_STEP  = 4'd7;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_ALT  = 3'd1;
  localparam logic [2:0] MUL_INT  = 3'd2;
  localparam logic [2:0] MUL_INC  = 3'd3;
  localparam logic [2:0] MUL_PG   = 3'd4;
  localparam logic [2:0] MUL_PIT  = 3'd5;

  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_CLIMB = 3'd2;
  localparam logic [2:0] OP_INNER = 3'd3;
  localparam logic [2:0] OP_ACC   = 3'd4;
  localparam logic [2:0] OP_FRAC  = 3'd5;
  localparam logic [2:0] OP_PITCH = 3'd6;
  localparam logic [2:0] OP_DONE  = 3'd7;

  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_IN   = 2'd1;
  localparam logic [1:0] COND_OUT  = 2'd2;

  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

  typedef struct packed {
    logic [2:0]        mul_sel;
    logic [2:0]        op;
    logic [1:0]        cond;
    logic              jump;
    logic [STEP_W-1:0] target;
  } vacc_ucode_t;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic [2:0] op;
    logic       fire;
    logic       in_ready;
  } vacc_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } vacc_stat_t;

  typedef struct packed {
    logic signed [31:0] altitude_gain;
    logic [30:0]        max_climb;
    logic [16:0]        cruise_throttle;
    logic signed [31:0] climb_increment;
    logic signed [31:0] throttle_pgain;
    logic signed [31:0] throttle_igain;
    logic signed [31:0] pitch_per_climb;
    logic [13:0]        slew_step;
  } vacc_cfg_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] climb_target;
    logic [13:0]        throttle_cmd;
    logic [13:0]        throttle_slewed;
    logic signed [31:0] pitch_cmd;
  } vacc_res_t;

  function automatic vacc_ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    vacc_ucode_t w;
    w = '{MUL_NONE, OP_NOP, COND_NONE, 1'b0, STEP_IDLE};
    case (step)
      3'd0: w = '{MUL_NONE, OP_LOAD,  COND_IN,   1'b0, STEP_IDLE};
      3'd1: w = '{MUL_ALT,  OP_NOP,   COND_NONE, 1'b0, STEP_IDLE};
      3'd2: w = '{MUL_INT,  OP_CLIMB, COND_NONE, 1'b0, STEP_IDLE};
      3'd3: w = '{MUL_INC,  OP_INNER, COND_NONE, 1'b0, STEP_IDLE};
      3'd4: w = '{MUL_PG,   OP_ACC,   COND_NONE, 1'b0, STEP_IDLE};
      3'd5: w = '{MUL_PIT,  OP_FRAC,  COND_NONE, 1'b0, STEP_IDLE};
      3'd6: w = '{MUL_NONE, OP_PITCH, COND_NONE, 1'b0, STEP_IDLE};
      3'd7: w = '{MUL_NONE, OP_DONE,  COND_OUT,  1'b1, STEP_IDLE};
      default: w = '{MUL_NONE, OP_NOP, COND_NONE, 1'b1, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/vacc_sequencer.sv
// Step counter and microcode lookup with wait conditions and jumps.
module vacc_sequencer
  import vacc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  vacc_stat_t stat,
  output vacc_ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  vacc_ucode_t       cw;
  logic              cond_ok;

  always_comb begin
    cw = ucode_rom(step);
    case (cw.cond)
      COND_NONE: cond_ok = 1'b1;
      COND_IN:   cond_ok = stat.in_valid;
      COND_OUT:  cond_ok = stat.out_free;
      default:   cond_ok = 1'b0;
    endcase
    if (!cond_ok) begin
      step_next = step;
    end else if (cw.jump) begin
      step_next = cw.target;
    end else begin
      step_next = step + 1'b1;
    end
    ctrl.mul_sel  = cw.mul_sel;
    ctrl.op       = cw.op;
    ctrl.fire     = cond_ok;
    ctrl.in_ready = (cw.cond == COND_IN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_IDLE && stat.in_valid) |=> (step == STEP_IDLE + 1'b1))
    else $error("accepted beat did not start the program");

  a_run_advances: assert property (@(posedge clk) disable iff (rst)
    (step != STEP_IDLE && step != STEP_LAST) |=> (step == $past(step) + 1'b1))
    else $error("program step did not advance");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_LAST && !stat.out_free) |=> (step == STEP_LAST))
    else $error("result step left while output busy");

  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_LAST && stat.out_free) |=> (step == STEP_IDLE))
    else $error("finished program did not return to idle");

endmodule

// File: rtl/vacc_datapath.sv
// Shared multiplier, working registers and per-step arithmetic of the controller.
module vacc_datapath
  import vacc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  vacc_ctrl_t         ctrl,
  input  vacc_cfg_t          cfg,
  input  logic signed [31:0] altitude_meas,
  input  logic signed [31:0] altitude_target,
  input  logic signed [31:0] pre_climb,
  input  logic signed [31:0] climb_rate_meas,
  input  logic signed [31:0] pitch_in,
  output vacc_res_t          res
);

  logic signed [31:0] aerr;
  logic signed [31:0] pre;
  logic signed [31:0] rate;
  logic signed [31:0] pitch;
  logic signed [63:0] prod;
  logic signed [31:0] climb;
  logic signed [32:0] err;
  logic signed [31:0] inner;
  logic signed [49:0] acc;
  logic [16:0]        frac;
  logic signed [31:0] pitch_out;
  logic [13:0]        cmd;
  logic signed [31:0] integ;
  logic [13:0]        slewed;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [47:0] prod_q;
  logic signed [32:0] aerr_w;
  logic signed [48:0] climb_sum;
  logic signed [48:0] max_w;
  logic signed [32:0] err_w;
  logic signed [48:0] inner_sum;
  logic signed [50:0] frac_sum;
  logic signed [48:0] pitch_sum;
  logic [30:0]        cmd_prod;
  logic signed [33:0] integ_sum;
  logic signed [15:0] diff;
  logic signed [15:0] step_w;
  logic signed [15:0] slewed_next;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_ALT: begin
        mul_a = cfg.altitude_gain;
        mul_b = aerr;
      end
      MUL_INT: begin
        mul_a = cfg.throttle_igain;
        mul_b = integ;
      end
      MUL_INC: begin
        mul_a = cfg.climb_increment;
        mul_b = climb;
      end
      MUL_PG: begin
        mul_a = cfg.throttle_pgain;
        mul_b = inner;
      end
      MUL_PIT: begin
        mul_a = climb;
        mul_b = cfg.pitch_per_climb;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    prod_q = prod[63:16];

    aerr_w = {altitude_meas[31], altitude_meas} - {altitude_target[31], altitude_target};

    climb_sum = {prod_q[47], prod_q} + {{17{pre[31]}}, pre};
    max_w = $signed({18'b0, cfg.max_climb});

    err_w = {rate[31], rate} - {climb[31], climb};
    inner_sum = {prod_q[47], prod_q} + {{16{err_w[32]}}, err_w};

    frac_sum = {acc[49], acc} + {{3{prod_q[47]}}, prod_q};

    pitch_sum = {prod_q[47], prod_q} + {{17{pitch[31]}}, pitch};
    cmd_prod = 31'(frac) * 31'(FULL_CMD);

    integ_sum = {{2{integ[31]}}, integ} + {err[32], err};
    diff = $signed({2'b0, cmd}) - $signed({2'b0, slewed});
    step_w = $signed({2'b0, cfg.slew_step});
    if (diff > step_w) begin
      slewed_next = $signed({2'b0, slewed}) + step_w;
    end else if (diff < -step_w) begin
      slewed_next = $signed({2'b0, slewed}) - step_w;
    end else begin
      slewed_next = $signed({2'b0, slewed}) + diff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.mul_sel != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_LOAD: begin
          if (aerr_w > 33'sd2147483647) begin
            aerr <= 32'sh7fffffff;
          end else if (aerr_w < -33'sd2147483648) begin
            aerr <= 32'sh80000000;
          end else begin
            aerr <= aerr_w[31:0];
          end
          pre   <= pre_climb;
          rate  <= climb_rate_meas;
          pitch <= pitch_in;
        end
        OP_CLIMB: begin
          if (climb_sum > max_w) begin
            climb <= max_w[31:0];
          end else if (climb_sum < -max_w) begin
            climb <= 32'(-max_w);
          end else begin
            climb <= climb_sum[31:0];
          end
        end
        OP_INNER: begin
          err <= err_w;
          if (inner_sum > 49'sd2147483647) begin
            inner <= 32'sh7fffffff;
          end else if (inner_sum < -49'sd2147483648) begin
            inner <= 32'sh80000000;
          end else begin
            inner <= inner_sum[31:0];
          end
        end
        OP_ACC: begin
          acc <= $signed({33'b0, cfg.cruise_throttle}) + {{2{prod_q[47]}}, prod_q};
        end
        OP_FRAC: begin
          if (frac_sum < 51'sd0) begin
            frac <= '0;
          end else if (frac_sum > $signed({34'b0, ONE_Q16})) begin
            frac <= ONE_Q16;
          end else begin
            frac <= frac_sum[16:0];
          end
        end
        OP_PITCH: begin
          if (pitch_sum > 49'sd2147483647) begin
            pitch_out <= 32'sh7fffffff;
          end else if (pitch_sum < -49'sd2147483648) begin
            pitch_out <= 32'sh80000000;
          end else begin
            pitch_out <= pitch_sum[31:0];
          end
          cmd <= cmd_prod[29:16];
        end
        default: begin
        end
      endcase
    end

    if (rst) begin
      integ  <= '0;
      slewed <= '0;
    end else if (ctrl.fire && ctrl.op == OP_DONE) begin
      if (integ_sum > INT_LIMIT) begin
        integ <= INT_LIMIT[31:0];
      end else if (integ_sum < -INT_LIMIT) begin
        integ <= 32'(-INT_LIMIT);
      end else begin
        integ <= integ_sum[31:0];
      end
      slewed <= slewed_next[13:0];
    end
  end

  assign res.done            = ctrl.fire && (ctrl.op == OP_DONE);
  assign res.climb_target    = climb;
  assign res.throttle_cmd    = cmd;
  assign res.throttle_slewed = slewed_next[13:0];
  assign res.pitch_cmd       = pitch_out;

endmodule

// File: rtl/vertical_altitude_climb_controller.sv
// Top level: stream ports, configuration registers and output register of the climb controller.
//
// One control tick per input beat. A tick runs the idle step that takes the beat and seven
// more steps of the microcode program; the last step writes the result into the output
// register. The program runs all five Q16.16 products through one shared, registered 32x32
// multiplier, one product per step. A new beat is taken once the program is back at its idle
// step; a result that waits on m_tready stalls the program only at its last step, when the
// output register is still full.
module vertical_altitude_climb_controller
  import vacc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // altitude_meas, altitude_target, pre_climb, climb_rate_meas, pitch_in
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // climb_target, throttle_cmd, throttle_slewed, pitch_cmd, 4 zero bits
  output logic [95:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  vacc_cfg_t  cfg;
  vacc_ctrl_t ctrl;
  vacc_stat_t stat;
  vacc_res_t  res;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.altitude_gain   <= '0;
      cfg.max_climb       <= 31'd131072;
      cfg.cruise_throttle <= 17'd29491;
      cfg.climb_increment <= '0;
      cfg.throttle_pgain  <= '0;
      cfg.throttle_igain  <= '0;
      cfg.pitch_per_climb <= '0;
      cfg.slew_step       <= FULL_CMD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALT_GAIN:   cfg.altitude_gain   <= cfg_data;
        REG_MAX_CLIMB:  cfg.max_climb       <= cfg_data[30:0];
        REG_CRUISE:     cfg.cruise_throttle <= cfg_data[16:0];
        REG_CLIMB_INC:  cfg.climb_increment <= cfg_data;
        REG_PGAIN:      cfg.throttle_pgain  <= cfg_data;
        REG_IGAIN:      cfg.throttle_igain  <= cfg_data;
        REG_PITCH_GAIN: cfg.pitch_per_climb <= cfg_data;
        REG_SLEW_STEP:  cfg.slew_step       <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  assign stat.in_valid = s_tvalid;
  assign stat.out_free = !m_tvalid || m_tready;
  assign s_tready      = ctrl.in_ready && !rst;

  vacc_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  vacc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .cfg             (cfg),
    .altitude_meas   (s_tdata[31:0]),
    .altitude_target (s_tdata[63:32]),
    .pre_climb       (s_tdata[95:64]),
    .climb_rate_meas (s_tdata[127:96]),
    .pitch_in        (s_tdata[159:128]),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res.done) begin
      m_tdata <= {4'b0, res.pitch_cmd, res.throttle_slewed, res.throttle_cmd,
                  res.climb_target};
    end
  end

endmodule

// File: bench/tb_vertical_altitude_climb_controller.sv
// Testbench: directed table and random control ticks for the climb controller, checked per beat.
module tb_vertical_altitude_climb_controller;
  import vacc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_PAUSE = 16;
  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  // indexes outside the register map
  localparam logic [3:0] REG_VOID_A = 4'd10;
  localparam logic [3:0] REG_VOID_B = 4'd15;
  localparam logic [3:0] REG_ORDER [8] = '{REG_ALT_GAIN, REG_MAX_CLIMB, REG_CRUISE,
    REG_CLIMB_INC, REG_PGAIN, REG_IGAIN, REG_PITCH_GAIN, REG_SLEW_STEP};
  localparam int NROWS = 44;

  typedef struct packed {
    logic signed [31:0] altitude_meas;
    logic signed [31:0] altitude_target;
    logic signed [31:0] pre_climb;
    logic signed [31:0] climb_rate_meas;
    logic signed [31:0] pitch_in;
  } climb_in_t;

  typedef struct packed {
    logic signed [31:0] climb_target;
    logic [13:0]        throttle_cmd;
    logic [13:0]        throttle_slewed;
    logic signed [31:0] pitch_cmd;
  } climb_out_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum logic [1:0] {PICK_FLIGHT, PICK_MIN, PICK_MAX, PICK_ANY} pick_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [3:0] reg_idx;
    logic [31:0] reg_val;
    climb_in_t  tick;
    logic       use_table;
    climb_out_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  vacc_cfg_t   ctl_regs;
  longint      rate_err_sum;
  logic [13:0] held_throttle;
  climb_out_t  pending_cmds [$];
  row_t        plan [NROWS];
  bit          idle_on = 1'b1;
  int unsigned mismatches = 0;
  int unsigned n_ticks = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  int unsigned cycles = 0;

  vertical_altitude_climb_controller u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint sat_word(input longint v);
    return clip(v, WORD_MIN, WORD_MAX);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic void apply_reg(input logic [3:0] idx, input logic [31:0] val);
    case (idx)
      REG_ALT_GAIN:   ctl_regs.altitude_gain = val;
      REG_MAX_CLIMB:  ctl_regs.max_climb = val[30:0];
      REG_CRUISE:     ctl_regs.cruise_throttle = val[16:0];
      REG_CLIMB_INC:  ctl_regs.climb_increment = val;
      REG_PGAIN:      ctl_regs.throttle_pgain = val;
      REG_IGAIN:      ctl_regs.throttle_igain = val;
      REG_PITCH_GAIN: ctl_regs.pitch_per_climb = val;
      REG_SLEW_STEP:  ctl_regs.slew_step = val[13:0];
      default: ;
    endcase
  endfunction

  // one control tick: outer P loop, inner PI loop, throttle scaling, slew and pitch command
  function automatic climb_out_t climb_tick(input climb_in_t x);
    longint alt_err, climb, err, inner, frac, cmd, lim, step, pitch_out;
    climb_out_t r;
    alt_err = sat_word(longint'(x.altitude_meas) - longint'(x.altitude_target));
    lim = longint'(ctl_regs.max_climb);
    climb = clip(fx_mul(ctl_regs.altitude_gain, alt_err) + longint'(x.pre_climb), -lim, lim);
    err = longint'(x.climb_rate_meas) - climb;
    inner = sat_word(err + fx_mul(ctl_regs.throttle_igain, rate_err_sum));
    frac = longint'(ctl_regs.cruise_throttle) + fx_mul(ctl_regs.climb_increment, climb)
         + fx_mul(ctl_regs.throttle_pgain, inner);
    frac = clip(frac, 0, longint'(ONE_Q16));
    cmd = (frac * longint'(FULL_CMD)) >>> 16;
    rate_err_sum = clip(rate_err_sum + err, -longint'(INT_LIMIT), longint'(INT_LIMIT));
    pitch_out = sat_word(longint'(x.pitch_in) + fx_mul(climb, ctl_regs.pitch_per_climb));
    step = longint'(ctl_regs.slew_step);
    held_throttle = 14'(longint'(held_throttle)
                  + clip(cmd - longint'(held_throttle), -step, step));
    r.climb_target = climb[31:0];
    r.throttle_cmd = cmd[13:0];
    r.throttle_slewed = held_throttle;
    r.pitch_cmd = pitch_out[31:0];
    return r;
  endfunction

  function automatic logic [31:0] small_signed(input int unsigned span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic logic [31:0] rand_field(input int unsigned span);
    if ($urandom_range(99) < 15) return $urandom;
    return small_signed(span);
  endfunction

  function automatic climb_in_t roll_tick();
    climb_in_t t;
    t.altitude_meas = rand_field(32'h01F4_0000);
    t.altitude_target = ($urandom_range(99) < 15) ? $urandom
                      : t.altitude_meas + small_signed(32'h0014_0000);
    t.pre_climb = rand_field(32'h0002_0000);
    t.climb_rate_meas = rand_field(32'h0006_0000);
    t.pitch_in = rand_field(32'h0001_0000);
    return t;
  endfunction

  function automatic logic [31:0] reg_value(input logic [3:0] idx, input pick_t p);
    logic unsigned_reg;
    unsigned_reg = (idx == REG_MAX_CLIMB) || (idx == REG_CRUISE) || (idx == REG_SLEW_STEP);
    case (p)
      PICK_ANY: return $urandom;
      PICK_MIN: return unsigned_reg ? 32'd0 : W_MIN;
      PICK_MAX: begin
        if (idx == REG_CRUISE) return 32'(ONE_Q16);
        if (idx == REG_SLEW_STEP) return 32'(FULL_CMD);
        return W_MAX;
      end
      default: ;
    endcase
    case (idx)
      REG_ALT_GAIN:   return small_signed(65536);
      REG_MAX_CLIMB:  return $urandom_range(327680);
      REG_CRUISE:     return $urandom_range(65536);
      REG_CLIMB_INC:  return small_signed(32768);
      REG_PGAIN:      return small_signed(6554);
      REG_IGAIN:      return small_signed(3277);
      REG_PITCH_GAIN: return small_signed(6554);
      default:        return $urandom_range(32'(FULL_CMD));
    endcase
  endfunction

  task automatic drive_tick(input climb_in_t t, input logic use_table, input climb_out_t tbl);
    climb_out_t model_out;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {t.pitch_in, t.climb_rate_meas, t.pre_climb, t.altitude_target, t.altitude_meas};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model_out = climb_tick(t);
    pending_cmds.push_back(use_table ? tbl : model_out);
    n_ticks++;
  endtask

  // drop valid, wait for every result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready <= !idle_on || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    climb_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[45:32], m_tdata[59:46], m_tdata[91:60]};
      if (pending_cmds.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        n_checked++;
        if (got.climb_target !== want.climb_target) begin
          $error("climb_target: expected %0d, got %0d", want.climb_target, got.climb_target);
          mismatches++;
        end
        if (got.throttle_cmd !== want.throttle_cmd) begin
          $error("throttle_cmd: expected %0d, got %0d", want.throttle_cmd, got.throttle_cmd);
          mismatches++;
        end
        if (got.throttle_slewed !== want.throttle_slewed) begin
          $error("throttle_slewed: expected %0d, got %0d",
                 want.throttle_slewed, got.throttle_slewed);
          mismatches++;
        end
        if (got.pitch_cmd !== want.pitch_cmd) begin
          $error("pitch_cmd: expected %0d, got %0d", want.pitch_cmd, got.pitch_cmd);
          mismatches++;
        end
        if (m_tdata[95:92] !== 4'd0) begin
          $error("pad bits: expected 0, got %0h", m_tdata[95:92]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pick_t pick;
    int n_items;
    ctl_regs = '{32'sd0, 31'd131072, 17'd29491, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 14'd9600};
    rate_err_sum = 0;
    held_throttle = '0;

    plan = '{
      // reset defaults: climb target is pre-climb clamped to 2.0, throttle at cruise
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        '{32'd0, 14'd4319, 14'd4319, 32'd0}},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, W_MAX, 32'd0, W_MAX}, 1'b1,
        '{32'h0002_0000, 14'd4319, 14'd4319, W_MAX}},
      '{ROW_ITEM, '0, '0, '{W_MAX, W_MIN, W_MIN, W_MAX, W_MIN}, 1'b1,
        '{32'hFFFE_0000, 14'd4319, 14'd4319, W_MIN}},
      // zero slew step holds the throttle
      '{ROW_CFG, REG_SLEW_STEP, 32'd0, '0, 1'b0, '0},
      '{ROW_CFG, REG_CLIMB_INC, 32'h0001_0000, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, W_MAX, 32'd0, 32'd0}, 1'b1,
        '{32'h0002_0000, 14'd9600, 14'd4319, 32'd0}},
      // oversized slew step, fraction clamped at zero
      '{ROW_CFG, REG_SLEW_STEP, 32'hFFFF_FFFF, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, W_MIN, 32'd0, 32'd0}, 1'b1,
        '{32'hFFFE_0000, 14'd0, 14'd0, 32'd0}},
      // oversized cruise saturates at full throttle
      '{ROW_CFG, REG_CLIMB_INC, 32'd0, '0, 1'b0, '0},
      '{ROW_CFG, REG_CRUISE, 32'hFFFF_FFFF, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        '{32'd0, 14'd9600, 14'd9600, 32'd0}},
      // writes to unmapped indexes change nothing
      '{ROW_CFG, REG_VOID_A, 32'd0, '0, 1'b0, '0},
      '{ROW_CFG, REG_VOID_B, 32'd0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1,
        '{32'd0, 14'd9600, 14'd9600, 32'd0}},
      // altitude error and pitch saturation
      '{ROW_CFG, REG_CRUISE, 32'd0, '0, 1'b0, '0},
      '{ROW_CFG, REG_SLEW_STEP, 32'd100, '0, 1'b0, '0},
      '{ROW_CFG, REG_ALT_GAIN, 32'h0001_0000, '0, 1'b0, '0},
      '{ROW_CFG, REG_MAX_CLIMB, W_MAX, '0, 1'b0, '0},
      '{ROW_CFG, REG_PITCH_GAIN, W_MAX, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{W_MAX, W_MIN, 32'd0, 32'd0, W_MAX}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{W_MIN, W_MAX, W_MIN, W_MIN, W_MIN}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'h0003_0000, 32'd0, 32'd0}, 1'b0, '0},
      // inner loop and integral driven into both limits
      '{ROW_CFG, REG_PGAIN, W_MAX, '0, 1'b0, '0},
      '{ROW_CFG, REG_IGAIN, W_MIN, '0, 1'b0, '0},
      '{ROW_CFG, REG_CLIMB_INC, 32'h0000_8000, '0, 1'b0, '0},
      '{ROW_CFG, REG_ALT_GAIN, W_MIN, '0, 1'b0, '0},
      '{ROW_CFG, REG_MAX_CLIMB, 32'd0, '0, 1'b0, '0},
      '{ROW_CFG, REG_PITCH_GAIN, W_MIN, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, W_MAX, 32'd0}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, W_MAX, 32'd0}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, W_MAX, 32'd0}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, W_MIN, 32'd0}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, W_MIN, 32'd0}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'd0, 32'd0, 32'd0, W_MIN, 32'd0}, 1'b0, '0},
      // ordinary flight values
      '{ROW_CFG, REG_MAX_CLIMB, 32'h0005_0000, '0, 1'b0, '0},
      '{ROW_CFG, REG_PGAIN, 32'h0000_0100, '0, 1'b0, '0},
      '{ROW_CFG, REG_IGAIN, 32'h0001_0000, '0, 1'b0, '0},
      '{ROW_CFG, REG_ALT_GAIN, 32'hFFFF_8000, '0, 1'b0, '0},
      '{ROW_CFG, REG_CRUISE, 32'd29491, '0, 1'b0, '0},
      '{ROW_CFG, REG_SLEW_STEP, 32'd9600, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'h0064_0000, 32'h0050_0000, 32'h0000_8000, 32'h0001_0000,
        32'h0000_1000}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'h0050_0000, 32'h0064_0000, 32'hFFFF_8000, 32'hFFFE_0000,
        32'hFFFF_F000}, 1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'h0060_0000, 32'h0060_0000, 32'd0, 32'h0000_4000, 32'd0},
        1'b0, '0},
      '{ROW_ITEM, '0, '0, '{32'hFF00_0000, 32'hFF10_0000, 32'h0001_0000, 32'd0,
        32'h0002_0000}, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        drive_tick(plan[i].tick, plan[i].use_table, plan[i].want);
      end
    end

    // first phase flight values with no idling, then all-max, all-min, then mixed
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      idle_on = (ph != 0);
      for (int r = 0; r < 8; r++) begin
        if (ph == 0) pick = PICK_FLIGHT;
        else if (ph == 1) pick = PICK_MAX;
        else if (ph == 2) pick = PICK_MIN;
        else begin
          case ($urandom_range(9))
            6: pick = PICK_MIN;
            7: pick = PICK_MAX;
            8: pick = PICK_ANY;
            default: pick = PICK_FLIGHT;
          endcase
        end
        write_reg(REG_ORDER[r], reg_value(REG_ORDER[r], pick));
      end
      if ($urandom_range(1) == 1) write_reg(REG_VOID_B - 4'($urandom_range(7)), $urandom);
      n_items = (ph == 0) ? 85 : ((ph < 3) ? 30 : 100);
      for (int k = 0; k < n_items; k++) drive_tick(roll_tick(), 1'b0, '0);
    end

    settle();
    $display("%0d control ticks sent, %0d results compared, %0d register writes",
             n_ticks, n_checked, n_writes);
    $display("covered saturation of every stage, slew freeze and unmapped register writes");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: vertical_altitude_climb_controller.f
rtl/vacc_pkg.sv
rtl/vacc_sequencer.sv
rtl/vacc_datapath.sv
rtl/vertical_altitude_climb_controller.sv
bench/tb_vertical_altitude_climb_controller.sv
